@@ rtl/core/tmf_pkg.sv @@
`timescale 1ns / 1ps

package tmf_pkg;

  localparam int MAX_PIXELS_DEF = 4096;
  localparam int MAX_WINDOW_DEF = 9;

  localparam int CFG_DATA_W   = 32;
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_WIN_W    = 4;
  localparam int CFG_FRAME_W  = 13;
  localparam int PIXEL_W      = 8;

  localparam logic [CFG_WIN_W-1:0]   WINDOW_LEN_RST   = CFG_WIN_W'(3);
  localparam logic [CFG_FRAME_W-1:0] FRAME_PIXELS_RST = CFG_FRAME_W'(4096);

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    REG_WINDOW_LEN   = 1'b0,
    REG_FRAME_PIXELS = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_MERGE,
    BK_RANK,
    BK_OUT
  } back_state_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

@@ rtl/core/temporal_median_pixel_filter_top.sv @@
`timescale 1ns / 1ps

// Temporal median filter for an 8-bit raster pixel stream. Each pixel replaces the current
// frame's sample of its position in a history memory of MAX_PIXELS rows of MAX_WINDOW bytes,
// and the block returns the lower median of that position's window_len samples plus a flag
// on the last pixel of each frame. The front part tracks position and frame slot and queues
// up to two pixels; the back part handles one pixel at a time in order (queue pop,
// history row read, merge and write-back, rank compare, result push, which waits while the
// result queue is full) and takes no new pixel until that push, so the read-modify-write of
// one history row never overlaps another. After reset the history is zeroed by a clearing
// pass over all MAX_PIXELS rows during which in_full stays high; configuration writes are
// taken throughout. window_len sits at byte address 0 and frame_pixels at byte address 4;
// write them only while no pixel is in flight.
module temporal_median_pixel_filter_top #(
  parameter int MAX_PIXELS = tmf_pkg::MAX_PIXELS_DEF,
  parameter int MAX_WINDOW = tmf_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [tmf_pkg::PIXEL_W-1:0]     in_pixel,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [tmf_pkg::PIXEL_W-1:0]     out_median,
  output logic                            out_frame_end,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [tmf_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [tmf_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [tmf_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import tmf_pkg::*;

  localparam int PW    = $clog2(MAX_PIXELS);
  localparam int SW    = $clog2(MAX_WINDOW);
  localparam int NW    = $clog2(MAX_WINDOW + 1);
  localparam int JOB_W = PW + SW + NW + PIXEL_W + 1;
  localparam int RES_W = PIXEL_W + 1;

  logic [CFG_WIN_W-1:0]   window_len_r, window_len_nxt;
  logic [CFG_FRAME_W-1:0] frame_pixels_r, frame_pixels_nxt;
  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  back_stat_t             back_stat;
  logic                   job_push;
  logic [JOB_W-1:0]       job_wdata;
  logic                   job_full;
  logic                   job_pop;
  logic [JOB_W-1:0]       job_rdata;
  logic                   job_empty;
  logic                   res_push;
  logic [RES_W-1:0]       res_wdata;
  logic                   res_full;
  logic [RES_W-1:0]       res_rdata;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[2]);

  always_comb begin
    window_len_nxt   = window_len_r;
    frame_pixels_nxt = frame_pixels_r;
    if (cfg_wr) begin
      case (cfg_idx)
        REG_WINDOW_LEN:   window_len_nxt   = cfg_pwdata[CFG_WIN_W-1:0];
        REG_FRAME_PIXELS: frame_pixels_nxt = cfg_pwdata[CFG_FRAME_W-1:0];
        default: ;
      endcase
    end
    case (cfg_idx)
      REG_WINDOW_LEN:   cfg_prdata = CFG_DATA_W'(window_len_r);
      REG_FRAME_PIXELS: cfg_prdata = CFG_DATA_W'(frame_pixels_r);
      default:          cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r   <= WINDOW_LEN_RST;
      frame_pixels_r <= FRAME_PIXELS_RST;
    end else begin
      window_len_r   <= window_len_nxt;
      frame_pixels_r <= frame_pixels_nxt;
    end
  end

  tmf_front #(
    .MAX_PIXELS (MAX_PIXELS),
    .MAX_WINDOW (MAX_WINDOW),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_pixel     (in_pixel),
    .window_len   (window_len_r),
    .frame_pixels (frame_pixels_r),
    .back_stat    (back_stat),
    .q_full       (job_full),
    .q_push       (job_push),
    .q_data       (job_wdata)
  );

  tmf_queue #(
    .W (JOB_W)
  ) u_job_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .wdata (job_wdata),
    .full  (job_full),
    .pop   (job_pop),
    .rdata (job_rdata),
    .empty (job_empty)
  );

  tmf_back #(
    .MAX_PIXELS (MAX_PIXELS),
    .MAX_WINDOW (MAX_WINDOW),
    .JOB_W      (JOB_W),
    .RES_W      (RES_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (job_empty),
    .q_data    (job_rdata),
    .q_pop     (job_pop),
    .back_stat (back_stat),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wdata)
  );

  tmf_queue #(
    .W (RES_W)
  ) u_res_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_wdata),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_median    = res_rdata[RES_W-1:1];
  assign out_frame_end = res_rdata[0];

endmodule

@@ rtl/core/tmf_queue.sv @@
`timescale 1ns / 1ps

module tmf_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);
  import tmf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/core/tmf_front.sv @@
`timescale 1ns / 1ps

module tmf_front #(
  parameter int MAX_PIXELS = tmf_pkg::MAX_PIXELS_DEF,
  parameter int MAX_WINDOW = tmf_pkg::MAX_WINDOW_DEF,
  parameter int JOB_W      = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_push,
  output logic                             in_full,
  input  logic [tmf_pkg::PIXEL_W-1:0]      in_pixel,
  input  logic [tmf_pkg::CFG_WIN_W-1:0]    window_len,
  input  logic [tmf_pkg::CFG_FRAME_W-1:0]  frame_pixels,
  input  tmf_pkg::back_stat_t              back_stat,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [JOB_W-1:0]                 q_data
);
  import tmf_pkg::*;

  localparam int PW  = $clog2(MAX_PIXELS);
  localparam int SW  = $clog2(MAX_WINDOW);
  localparam int NW  = $clog2(MAX_WINDOW + 1);
  localparam int FW  = PW + 1;
  localparam int CW  = (FW > CFG_FRAME_W) ? FW : CFG_FRAME_W;
  localparam int NCW = (NW > CFG_WIN_W) ? NW : CFG_WIN_W;

  typedef struct packed {
    logic [PW-1:0]      pos;
    logic [SW-1:0]      slot;
    logic [NW-1:0]      n;
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } job_t;

  logic [PW-1:0]  position_r, position_nxt;
  logic [SW-1:0]  frame_slot_r, frame_slot_nxt;
  logic [CW-1:0]  fp_ext;
  logic [CW-1:0]  eff_f;
  logic [CW-1:0]  pos_inc;
  logic [NCW-1:0] wl_ext;
  logic [NW-1:0]  eff_n;
  logic [SW-1:0]  slot;
  logic [NW-1:0]  slot_inc;
  logic           last;
  logic           accept;
  job_t           job;

  assign in_full = q_full || back_stat.clearing;
  assign accept  = in_push && !in_full;
  assign q_push  = accept;

  always_comb begin
    fp_ext = CW'(frame_pixels);
    if (fp_ext == '0) begin
      eff_f = CW'(1);
    end else if (fp_ext > CW'(MAX_PIXELS)) begin
      eff_f = CW'(MAX_PIXELS);
    end else begin
      eff_f = fp_ext;
    end

    wl_ext = NCW'(window_len);
    if (wl_ext == '0) begin
      eff_n = NW'(1);
    end else if (wl_ext > NCW'(MAX_WINDOW)) begin
      eff_n = NW'(MAX_WINDOW);
    end else begin
      eff_n = NW'(wl_ext);
    end

    slot     = (NW'(frame_slot_r) < eff_n) ? frame_slot_r : '0;
    slot_inc = NW'(slot) + 1'b1;
    pos_inc  = CW'(position_r) + 1'b1;
    last     = (pos_inc >= eff_f);

    job.pos   = position_r;
    job.slot  = slot;
    job.n     = eff_n;
    job.pixel = in_pixel;
    job.last  = last;
    q_data    = job;

    position_nxt   = position_r;
    frame_slot_nxt = frame_slot_r;
    if (accept) begin
      if (last) begin
        position_nxt   = '0;
        frame_slot_nxt = (slot_inc >= eff_n) ? '0 : SW'(slot_inc);
      end else begin
        position_nxt = position_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r   <= '0;
      frame_slot_r <= '0;
    end else begin
      position_r   <= position_nxt;
      frame_slot_r <= frame_slot_nxt;
    end
  end

endmodule

@@ rtl/core/tmf_back.sv @@
`timescale 1ns / 1ps

module tmf_back #(
  parameter int MAX_PIXELS = tmf_pkg::MAX_PIXELS_DEF,
  parameter int MAX_WINDOW = tmf_pkg::MAX_WINDOW_DEF,
  parameter int JOB_W      = 8,
  parameter int RES_W      = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  logic [JOB_W-1:0]    q_data,
  output logic                q_pop,
  output tmf_pkg::back_stat_t back_stat,
  input  logic                res_full,
  output logic                res_push,
  output logic [RES_W-1:0]    res_data
);
  import tmf_pkg::*;

  localparam int PW   = $clog2(MAX_PIXELS);
  localparam int SW   = $clog2(MAX_WINDOW);
  localparam int NW   = $clog2(MAX_WINDOW + 1);
  localparam int ROWW = MAX_WINDOW * PIXEL_W;

  typedef struct packed {
    logic [PW-1:0]      pos;
    logic [SW-1:0]      slot;
    logic [NW-1:0]      n;
    logic [PIXEL_W-1:0] pixel;
    logic               last;
  } job_t;

  logic [ROWW-1:0]       mem [MAX_PIXELS];
  logic [ROWW-1:0]       rd_row_r;
  logic [ROWW-1:0]       row_r, row_nxt;
  back_state_t           state_r, state_nxt;
  job_t                  job_r, job_nxt;
  logic [PW-1:0]         clr_addr_r, clr_addr_nxt;
  logic [MAX_WINDOW-1:0] sel_r, sel_nxt;
  logic                  mem_we;
  logic [PW-1:0]         mem_waddr;
  logic [ROWW-1:0]       mem_wdata;
  logic [PIXEL_W-1:0]    samp [MAX_WINDOW];
  logic [NW-1:0]         rank [MAX_WINDOW];
  logic [NW-1:0]         mid;
  logic [PIXEL_W-1:0]    median;

  assign back_stat.clearing = (state_r == BK_CLEAR);

  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      samp[i] = row_r[i*PIXEL_W +: PIXEL_W];
    end
    mid = (job_r.n - 1'b1) >> 1;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      rank[i] = '0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
        if ((NW'(j) < job_r.n) &&
            ((samp[j] < samp[i]) || ((samp[j] == samp[i]) && (j < i)))) begin
          rank[i] = rank[i] + 1'b1;
        end
      end
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      sel_nxt[i] = (NW'(i) < job_r.n) && (rank[i] == mid);
    end
    median = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (sel_r[i]) begin
        median = median | samp[i];
      end
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      row_nxt[i*PIXEL_W +: PIXEL_W] = (SW'(i) == job_r.slot) ?
        job_r.pixel : rd_row_r[i*PIXEL_W +: PIXEL_W];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    job_nxt      = job_r;
    clr_addr_nxt = clr_addr_r;
    q_pop        = 1'b0;
    res_push     = 1'b0;
    res_data     = {median, job_r.last};
    mem_we       = 1'b0;
    mem_waddr    = job_r.pos;
    mem_wdata    = row_nxt;
    case (state_r)
      BK_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == PW'(MAX_PIXELS - 1)) begin
          state_nxt = BK_IDLE;
        end
      end
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = job_t'(q_data);
          state_nxt = BK_READ;
        end
      end
      BK_READ: begin
        state_nxt = BK_MERGE;
      end
      BK_MERGE: begin
        mem_we    = 1'b1;
        state_nxt = BK_RANK;
      end
      BK_RANK: begin
        state_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    sel_r <= (state_r == BK_RANK) ? sel_nxt : sel_r;
    row_r <= (state_r == BK_MERGE) ? row_nxt : row_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_row_r <= mem[job_r.pos];
  end

endmodule
